/* hw/rtl/mpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg
// Types and constants shared by the priority queue top level and its cells.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int Capacity = 16;
	localparam int CntW     = $clog2(Capacity + 1);

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_REMOVED  = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef struct packed {
		logic        func;
		logic [7:0]  priority_req;
		logic [15:0] process_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_priority;
		logic [15:0] out_process_id;
		logic [4:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] pid;
	} entry_t;

	// Operation broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

/* hw/rtl/mpq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted chain: holds an entry, shifts towards the tail on an
// insert above it and towards the head on a removal.
// ----------------------------------------------------------------------------
module mpq_cell (
	input  logic               clk,
	input  mpq_pkg::cell_ctrl_t ctrl,
	input  mpq_pkg::entry_t    new_entry,
	input  logic               occupied,
	input  logic               head_ge,
	input  mpq_pkg::entry_t    head_entry,
	input  mpq_pkg::entry_t    tail_entry,
	output logic               ge,
	output mpq_pkg::entry_t    entry
);

	mpq_pkg::entry_t entry_q;

	// The new entry belongs at or above this slot when the slot is empty or
	// holds a priority no larger than the new one.
	assign ge    = !occupied || (new_entry.prio >= entry_q.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (head_ge) begin
				entry_q <= head_entry;
			end else if (ge) begin
				entry_q <= new_entry;
			end
		end else if (ctrl.rem) begin
			entry_q <= tail_entry;
		end
	end

endmodule

/* hw/rtl/max_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_priority_queue
// Bounded max-priority queue of process entries built as a chain of cells.
// ----------------------------------------------------------------------------
// The queue holds up to sixteen entries of an 8-bit priority and a 16-bit
// process id in a row of cells kept sorted with the largest priority at the
// head. An insert beat places the new entry above every entry of equal
// priority, so among equal maxima the newest leaves first; a remove beat pops
// the head cell. Every request beat yields exactly one response beat carrying
// a status, the removed entry (zero on inserts and failed removals) and the
// number of entries held afterwards. On each request, every cell compares its
// own priority with the new one and shifts in step with its neighbours, and
// the response is registered, so one beat follows another in every cycle
// while the response side keeps taking beats. A new request is accepted
// while the response register is empty or being drained. No clearing pass
// follows reset; cells above the fill count are never read.
// ----------------------------------------------------------------------------
module max_priority_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mpq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mpq_pkg::rsp_t  rsp
);

	localparam int N = mpq_pkg::Capacity;
	localparam int W = mpq_pkg::CntW;

	logic [W-1:0]        count_q;
	logic                rsp_valid_q;
	mpq_pkg::rsp_t       rsp_q;

	logic                acc;
	logic                is_full;
	logic                is_empty;
	mpq_pkg::cell_ctrl_t ctrl;
	mpq_pkg::entry_t     new_entry;
	mpq_pkg::entry_t     cell_entry [N];
	logic                cell_ge    [N];
	logic [W-1:0]        count_next;
	mpq_pkg::rsp_t       rsp_next;

	// The output register frees up in the same cycle it is drained.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign acc       = req_valid && req_ready;
	assign is_full   = (count_q == W'(N));
	assign is_empty  = (count_q == '0);

	assign new_entry.prio = req.priority_req;
	assign new_entry.pid  = req.process_id;

	// Cells only move when the operation actually changes the contents.
	assign ctrl.ins = acc && (req.func == mpq_pkg::FUNC_INSERT) && !is_full;
	assign ctrl.rem = acc && (req.func == mpq_pkg::FUNC_REMOVE) && !is_empty;

	// The chain: cell zero is the head and holds the maximum.
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic            head_ge;
		mpq_pkg::entry_t head_entry;
		mpq_pkg::entry_t tail_entry;

		if (i == 0) begin : g_head
			assign head_ge    = 1'b0;
			assign head_entry = new_entry;
		end else begin : g_body
			assign head_ge    = cell_ge[i-1];
			assign head_entry = cell_entry[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign tail_entry = cell_entry[i];
		end else begin : g_link
			assign tail_entry = cell_entry[i+1];
		end

		mpq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.occupied   (count_q > W'(i)),
			.head_ge    (head_ge),
			.head_entry (head_entry),
			.tail_entry (tail_entry),
			.ge         (cell_ge[i]),
			.entry      (cell_entry[i])
		);
	end

	always_comb begin
		count_next              = count_q;
		rsp_next.out_priority   = '0;
		rsp_next.out_process_id = '0;
		if (req.func == mpq_pkg::FUNC_INSERT) begin
			if (is_full) begin
				rsp_next.status = mpq_pkg::ST_FULL;
			end else begin
				rsp_next.status = mpq_pkg::ST_INSERTED;
				count_next      = count_q + W'(1);
			end
		end else begin
			if (is_empty) begin
				rsp_next.status = mpq_pkg::ST_EMPTY;
			end else begin
				rsp_next.status         = mpq_pkg::ST_REMOVED;
				rsp_next.out_priority   = cell_entry[0].prio;
				rsp_next.out_process_id = cell_entry[0].pid;
				count_next              = count_q - W'(1);
			end
		end
		rsp_next.entry_count = 5'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The fill count never passes the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= W'(N))
		else $error("fill count above capacity");

	// Every accepted request leaves a response waiting in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp_valid)
		else $error("accepted request produced no response");

	// An insert into a full queue is flagged and leaves the count alone.
	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.func == mpq_pkg::FUNC_INSERT && is_full)
		|=> (rsp.status == mpq_pkg::ST_FULL) && $stable(count_q))
		else $error("insert into full queue not rejected");

	// The head cell holds a priority no smaller than its neighbour.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
		else $error("head of chain out of order");

endmodule
